// File: design/tbps_pkg.sv
package tbps_pkg;

  localparam int unsigned FieldW = 16;
  localparam int unsigned CountW = 5;

  typedef enum logic [2:0] {
    OUT_TOKEN_KEPT    = 3'd0,
    OUT_TOKEN_DROPPED = 3'd1,
    OUT_PKT_QUEUED    = 3'd2,
    OUT_DROP_OVERSIZE = 3'd3,
    OUT_DROP_FULL     = 3'd4
  } outcome_e;

  typedef enum logic {
    MODE_TICK   = 1'b0,
    MODE_PACKET = 1'b1
  } mode_e;

  // request from the shaper to the wait queue
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [FieldW-1:0] id;
    logic [FieldW-1:0] need;
  } queue_ctl_t;

  // wait queue status seen by the shaper
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [FieldW-1:0] head_id;
    logic [FieldW-1:0] head_need;
  } queue_sts_t;

  // one result transaction
  typedef struct packed {
    outcome_e          outcome;
    logic              released;
    logic [FieldW-1:0] released_id;
    logic [FieldW-1:0] bucket_level;
    logic [CountW-1:0] queue_count;
  } result_t;

endpackage

// File: design/tbps_if.sv
interface tbps_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] packet_id;
  logic [15:0] tokens_needed;

  modport source (output valid, mode, packet_id, tokens_needed, input ready);
  modport sink   (input valid, mode, packet_id, tokens_needed, output ready);
endinterface

interface tbps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic        released;
  logic [15:0] released_id;
  logic [15:0] bucket_level;
  logic [4:0]  queue_count;

  modport source (output valid, outcome, released, released_id, bucket_level, queue_count,
                  input ready);
  modport sink   (input valid, outcome, released, released_id, bucket_level, queue_count,
                  output ready);
endinterface

interface tbps_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: design/tbps_queue.sv
module tbps_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tbps_pkg::queue_ctl_t                  ctl_i,
  output tbps_pkg::queue_sts_t                  sts_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      fill_nxt_o
);
  import tbps_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DW = 2 * FieldW;

  logic [DW-1:0] mem [QUEUE_DEPTH];
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [DW-1:0] head_data_q;
  logic [DW-1:0] wr_data;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] ptr);
    next_slot = (ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : ptr + AW'(1);
  endfunction

  assign wr_data = {ctl_i.id, ctl_i.need};

  always_comb begin
    head_d = ctl_i.pop  ? next_slot(head_q) : head_q;
    tail_d = ctl_i.push ? next_slot(tail_q) : tail_q;
    fill_d = fill_q + FW'(ctl_i.push) - FW'(ctl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // entry storage, head entry kept in a read register
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= wr_data;
    end
    // a push into an empty queue lands on the next head
    if (ctl_i.push && (tail_q == head_d)) begin
      head_data_q <= wr_data;
    end else begin
      head_data_q <= mem[head_d];
    end
  end

  assign sts_o.empty     = (fill_q == '0);
  assign sts_o.full      = (fill_q == FW'(QUEUE_DEPTH));
  assign sts_o.head_id   = head_data_q[DW-1:FieldW];
  assign sts_o.head_need = head_data_q[FieldW-1:0];
  assign fill_nxt_o      = fill_d;

endmodule

// File: design/tbps_shaper.sv
module tbps_shaper #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic                             mode_i,
  input  logic [15:0]                      packet_id_i,
  input  logic [15:0]                      tokens_needed_i,
  input  logic [15:0]                      bucket_size_i,
  input  tbps_pkg::queue_sts_t             sts_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] fill_nxt_i,
  output tbps_pkg::queue_ctl_t             ctl_o,
  output tbps_pkg::result_t                res_o
);
  import tbps_pkg::*;

  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  logic [FieldW-1:0]    level_q, level_d;
  logic [FieldW-1:0]    tick_level;
  logic [FW+CountW-1:0] fill_ext;

  // queue count goes out as its low five bits
  assign fill_ext = {{CountW{1'b0}}, fill_nxt_i};

  always_comb begin
    ctl_o            = '0;
    ctl_o.id         = packet_id_i;
    ctl_o.need       = tokens_needed_i;
    res_o            = '0;
    level_d          = level_q;
    tick_level       = level_q;
    if (mode_i == MODE_TICK) begin
      if (level_q < bucket_size_i) begin
        tick_level    = level_q + FieldW'(1);
        res_o.outcome = OUT_TOKEN_KEPT;
      end else begin
        res_o.outcome = OUT_TOKEN_DROPPED;
      end
      level_d = tick_level;
      if (!sts_i.empty && (tick_level >= sts_i.head_need)) begin
        level_d           = tick_level - sts_i.head_need;
        res_o.released    = 1'b1;
        res_o.released_id = sts_i.head_id;
        ctl_o.pop         = step_i;
      end
    end else if (tokens_needed_i > bucket_size_i) begin
      res_o.outcome = OUT_DROP_OVERSIZE;
    end else if (sts_i.empty && (level_q >= tokens_needed_i)) begin
      // straight through, never stored
      level_d           = level_q - tokens_needed_i;
      res_o.outcome     = OUT_PKT_QUEUED;
      res_o.released    = 1'b1;
      res_o.released_id = packet_id_i;
    end else if (sts_i.full) begin
      res_o.outcome = OUT_DROP_FULL;
    end else begin
      res_o.outcome = OUT_PKT_QUEUED;
      ctl_o.push    = step_i;
    end
    res_o.bucket_level = level_d;
    res_o.queue_count  = fill_ext[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (step_i) begin
      level_q <= level_d;
    end
  end

endmodule

// File: design/token_bucket_packet_shaper.sv
// channel  | dir | modport | payload
// pkt_in   | in  | sink    | mode, packet_id, tokens_needed
// res_out  | out | source  | outcome, released, released_id, bucket_level, queue_count
// cfg_wr   | in  | sink    | data (bucket_size), always ready
//
// one transaction per cycle sustained while res_out is not stalled; an accepted input
// moves from the input register, through the bucket and queue update, into the result register
// the bucket level and queue pointers update in the same cycle that makes the result,
// so the next item sees them with no gap
// rst_ni clears the bucket, the queue pointers and both stage valids; bucket_size
// comes out of reset at 10, queue storage is not cleared
// a stalled result holds in the result register while one more item waits in the
// input register; pkt_in.ready drops only when both are full and res_out is stalled
module token_bucket_packet_shaper #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbps_in_if.sink    pkt_in,
  tbps_out_if.source res_out,
  tbps_cfg_if.sink   cfg_wr
);
  import tbps_pkg::*;

  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FieldW-1:0] BucketSizeRst = FieldW'(10);

  // configuration register
  logic [FieldW-1:0] bucket_size_q;

  // input stage
  logic              in_valid_q, in_valid_d;
  logic              in_mode_q;
  logic [FieldW-1:0] in_id_q;
  logic [FieldW-1:0] in_need_q;

  // result stage
  logic              out_valid_q, out_valid_d;
  result_t           out_res_q;

  // step datapath
  logic              in_fire;
  logic              advance;
  queue_ctl_t        q_ctl;
  queue_sts_t        q_sts;
  logic [FW-1:0]     q_fill_nxt;
  result_t           step_res;

  // the input stage moves on whenever the result register is free or draining
  assign advance      = in_valid_q && (!out_valid_q || res_out.ready);
  assign pkt_in.ready = !in_valid_q || advance;
  assign in_fire      = pkt_in.valid && pkt_in.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (res_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_mode_q <= pkt_in.mode;
      in_id_q   <= pkt_in.packet_id;
      in_need_q <= pkt_in.tokens_needed;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  // bucket size, written only while idle: a rule for the user, the block itself does not enforce it
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_size_q <= BucketSizeRst;
    end else if (cfg_wr.valid) begin
      bucket_size_q <= cfg_wr.data;
    end
  end

  // token bucket and release decision
  tbps_shaper #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_shaper (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .mode_i          (in_mode_q),
    .packet_id_i     (in_id_q),
    .tokens_needed_i (in_need_q),
    .bucket_size_i   (bucket_size_q),
    .sts_i           (q_sts),
    .fill_nxt_i      (q_fill_nxt),
    .ctl_o           (q_ctl),
    .res_o           (step_res)
  );

  // packet wait queue with a registered head entry
  tbps_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (q_ctl),
    .sts_o      (q_sts),
    .fill_nxt_o (q_fill_nxt)
  );

  assign res_out.valid        = out_valid_q;
  assign res_out.outcome      = out_res_q.outcome;
  assign res_out.released     = out_res_q.released;
  assign res_out.released_id  = out_res_q.released_id;
  assign res_out.bucket_level = out_res_q.bucket_level;
  assign res_out.queue_count  = out_res_q.queue_count;

endmodule

// File: design/tbps_checker.sv
module tbps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  outcome_i,
  input logic        released_i,
  input logic [15:0] released_id_i,
  input logic [15:0] bucket_level_i
);
  import tbps_pkg::*;

  // no release means a zero id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !released_i) |-> (released_id_i == 16'd0))
    else $error("released_id nonzero without a release");

  // dropped packets never release anything
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && ((outcome_i == OUT_DROP_OVERSIZE) || (outcome_i == OUT_DROP_FULL)))
      |-> !released_i)
    else $error("release reported on a dropped packet");

  // a kept token with nothing released leaves at least one token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (outcome_i == OUT_TOKEN_KEPT) && !released_i)
      |-> (bucket_level_i != 16'd0))
    else $error("bucket empty after a kept token");

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result withdrawn while stalled");

endmodule

bind token_bucket_packet_shaper tbps_checker u_tbps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (res_out.valid),
  .out_ready_i    (res_out.ready),
  .outcome_i      (res_out.outcome),
  .released_i     (res_out.released),
  .released_id_i  (res_out.released_id),
  .bucket_level_i (res_out.bucket_level)
);

// File: verif/tb_token_bucket_packet_shaper.sv
`timescale 1ns / 100ps

module tb_token_bucket_packet_shaper;
  import tbps_pkg::*;

  localparam int QDepth        = 16;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 3;
  localparam int NumSegments   = 8;
  localparam int SegmentItems  = 88;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // one line of the directed table; value is tokens_needed or the new bucket size
  typedef struct packed {
    row_kind_e   kind;
    mode_e       mode;
    logic [15:0] id;
    logic [15:0] value;
    logic [7:0]  reps;
    logic        fixed;
    result_t     res;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tbps_in_if  pkt_if ();
  tbps_out_if res_if ();
  tbps_cfg_if cfg_if ();

  token_bucket_packet_shaper #(
    .QUEUE_DEPTH(QDepth)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pkt_in (pkt_if),
    .res_out(res_if),
    .cfg_wr (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shaper state as the testbench sees it, updated on every accepted input and size write
  logic [15:0] bucket_cap    = 16'd10;
  logic [15:0] bucket_tokens = 16'd0;
  logic [15:0] wait_ids   [QDepth];
  logic [15:0] wait_needs [QDepth];
  int          wait_head  = 0;
  int          wait_tail  = 0;
  int          wait_fill  = 0;

  result_t     shaped_q[$];   // results still owed by the block, oldest first

  // expectation typed into the table travels with the item being driven
  logic        row_fixed;
  result_t     row_res;

  int          idle_pct  = 0;
  int          stall_pct = 0;

  int          fail_count     = 0;
  int          results_seen   = 0;
  int          ticks_sent     = 0;
  int          arrivals_sent  = 0;
  int          releases_seen  = 0;
  int          oversize_seen  = 0;
  int          full_seen      = 0;
  int          sizes_used     = 0;

  // one shaper step: tick or arrival, bucket first, then the wait queue head
  function automatic result_t shape_step(mode_e mode, logic [15:0] id, logic [15:0] need);
    result_t r;
    r = '0;
    if (mode == MODE_TICK) begin
      if (bucket_tokens < bucket_cap) begin
        bucket_tokens = bucket_tokens + 16'd1;
        r.outcome = OUT_TOKEN_KEPT;
      end else begin
        // level may sit above a lowered size, it is kept as it is
        r.outcome = OUT_TOKEN_DROPPED;
      end
      if (wait_fill != 0 && bucket_tokens >= wait_needs[wait_head]) begin
        bucket_tokens = bucket_tokens - wait_needs[wait_head];
        r.released    = 1'b1;
        r.released_id = wait_ids[wait_head];
        wait_head     = (wait_head == QDepth - 1) ? 0 : wait_head + 1;
        wait_fill--;
      end
    end else if (need > bucket_cap) begin
      r.outcome = OUT_DROP_OVERSIZE;
    end else if (wait_fill == 0 && bucket_tokens >= need) begin
      // empty queue and enough tokens: straight through
      bucket_tokens = bucket_tokens - need;
      r.outcome     = OUT_PKT_QUEUED;
      r.released    = 1'b1;
      r.released_id = id;
    end else if (wait_fill >= QDepth) begin
      r.outcome = OUT_DROP_FULL;
    end else begin
      // joins the wait queue, only a later tick can let it go
      wait_ids[wait_tail]   = id;
      wait_needs[wait_tail] = need;
      wait_tail             = (wait_tail == QDepth - 1) ? 0 : wait_tail + 1;
      wait_fill++;
      r.outcome = OUT_PKT_QUEUED;
    end
    r.bucket_level = bucket_tokens;
    r.queue_count  = 5'(wait_fill);
    return r;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  // receiver side: random stalls on the result channel
  always @(posedge clk_i) res_if.ready <= ($urandom_range(99) >= stall_pct);

  // monitor: check results against the oldest expectation, predict on accepted input
  always @(posedge clk_i) begin
    result_t owed;
    result_t pred;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (shaped_q.size() == 0) begin
          note_failure($sformatf("result with nothing owed: outcome %0d rel %0b id %h level %0d count %0d",
                                 res_if.outcome, res_if.released, res_if.released_id,
                                 res_if.bucket_level, res_if.queue_count));
        end else begin
          owed = shaped_q.pop_front();
          if (owed.released) releases_seen++;
          if (owed.outcome == OUT_DROP_OVERSIZE) oversize_seen++;
          if (owed.outcome == OUT_DROP_FULL) full_seen++;
          if (res_if.outcome !== owed.outcome || res_if.released !== owed.released ||
              res_if.released_id !== owed.released_id ||
              res_if.bucket_level !== owed.bucket_level ||
              res_if.queue_count !== owed.queue_count) begin
            note_failure($sformatf({"result %0d expected outcome %0d rel %0b id %h level %0d count %0d",
                                    ", got outcome %0d rel %0b id %h level %0d count %0d"},
                                   results_seen, owed.outcome, owed.released, owed.released_id,
                                   owed.bucket_level, owed.queue_count, res_if.outcome,
                                   res_if.released, res_if.released_id, res_if.bucket_level,
                                   res_if.queue_count));
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) bucket_cap = cfg_if.data;
      if (pkt_if.valid && pkt_if.ready) begin
        pred = shape_step(mode_e'(pkt_if.mode), pkt_if.packet_id, pkt_if.tokens_needed);
        shaped_q.push_back(row_fixed ? row_res : pred);
      end
    end
  end

  // watchdog: too long without any transaction on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no transaction for %0d cycles, %0d results still owed", WatchdogLimit,
             shaped_q.size());
    $display("tb_token_bucket_packet_shaper failed");
    $finish;
  end

  // one input transaction, with random sender gaps ahead of it
  task automatic send_item(mode_e mode, logic [15:0] id, logic [15:0] need, logic fixed,
                           result_t res);
    while ($urandom_range(99) < idle_pct) begin
      pkt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pkt_if.valid         <= 1'b1;
    pkt_if.mode          <= mode;
    pkt_if.packet_id     <= id;
    pkt_if.tokens_needed <= need;
    row_fixed            <= fixed;
    row_res              <= res;
    @(posedge clk_i);
    while (!pkt_if.ready) @(posedge clk_i);
    if (mode == MODE_TICK) ticks_sent++;
    else arrivals_sent++;
  endtask

  // hold the sender until every owed result is in, then let the pipe settle
  task automatic wait_idle();
    pkt_if.valid <= 1'b0;
    @(posedge clk_i);
    while (shaped_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cap(logic [15:0] cap);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cap;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    sizes_used++;
  endtask

  // tick until the wait queue is empty so no head is stranded by a smaller size
  task automatic drain_queue();
    wait_idle();
    while (wait_fill != 0) begin
      send_item(MODE_TICK, 16'h0, 16'h0, 1'b0, '0);
      wait_idle();
    end
  endtask

  initial begin
    stim_row_t   dir_table [15];
    int          seg_cap [NumSegments];
    logic [15:0] cap;
    logic [15:0] need;
    int          tick_pct;

    pkt_if.valid         <= 1'b0;
    pkt_if.mode          <= MODE_TICK;
    pkt_if.packet_id     <= 16'h0;
    pkt_if.tokens_needed <= 16'h0;
    cfg_if.valid         <= 1'b0;
    cfg_if.data          <= 16'h0;
    row_fixed            <= 1'b0;
    row_res              <= '0;

    // directed table: reset state, extremes, each outcome and the corner cases
    dir_table = '{
      // first tick after reset
      '{ROW_ITEM, MODE_TICK,   16'h0000, 16'h0000, 8'd1,  1'b1,
        '{OUT_TOKEN_KEPT,    1'b0, 16'h0000, 16'd1, 5'd0}},
      // zero need goes straight through, top id
      '{ROW_ITEM, MODE_PACKET, 16'hFFFF, 16'h0000, 8'd1,  1'b1,
        '{OUT_PKT_QUEUED,    1'b1, 16'hFFFF, 16'd1, 5'd0}},
      // largest need and one above the size
      '{ROW_ITEM, MODE_PACKET, 16'h1234, 16'hFFFF, 8'd1,  1'b1,
        '{OUT_DROP_OVERSIZE, 1'b0, 16'h0000, 16'd1, 5'd0}},
      '{ROW_ITEM, MODE_PACKET, 16'hAAAA, 16'd11,   8'd1,  1'b1,
        '{OUT_DROP_OVERSIZE, 1'b0, 16'h0000, 16'd1, 5'd0}},
      // not enough tokens, waits
      '{ROW_ITEM, MODE_PACKET, 16'h5555, 16'd3,    8'd1,  1'b1,
        '{OUT_PKT_QUEUED,    1'b0, 16'h0000, 16'd1, 5'd1}},
      // affordable but behind another packet, must wait too
      '{ROW_ITEM, MODE_PACKET, 16'h0001, 16'd1,    8'd1,  1'b1,
        '{OUT_PKT_QUEUED,    1'b0, 16'h0000, 16'd1, 5'd2}},
      // ticks release the two waiting packets in order
      '{ROW_ITEM, MODE_TICK,   16'h0000, 16'h0000, 8'd3,  1'b0, '0},
      '{ROW_ITEM, MODE_TICK,   16'h0000, 16'h0000, 8'd1,  1'b0, '0},
      // zero size with one token left, so level sits above size
      '{ROW_CFG,  MODE_TICK,   16'h0000, 16'd0,    8'd1,  1'b0, '0},
      '{ROW_ITEM, MODE_TICK,   16'h0000, 16'h0000, 8'd1,  1'b1,
        '{OUT_TOKEN_DROPPED, 1'b0, 16'h0000, 16'd1, 5'd0}},
      '{ROW_ITEM, MODE_PACKET, 16'h00FF, 16'd0,    8'd1,  1'b1,
        '{OUT_PKT_QUEUED,    1'b1, 16'h00FF, 16'd1, 5'd0}},
      '{ROW_ITEM, MODE_PACKET, 16'h0F0F, 16'd1,    8'd1,  1'b1,
        '{OUT_DROP_OVERSIZE, 1'b0, 16'h0000, 16'd1, 5'd0}},
      // size one: first spends the last token, the next sixteen fill the queue
      '{ROW_CFG,  MODE_TICK,   16'h0000, 16'd1,    8'd1,  1'b0, '0},
      '{ROW_ITEM, MODE_PACKET, 16'h8000, 16'd1,    8'd17, 1'b0, '0},
      // full queue drops and leaves state alone
      '{ROW_ITEM, MODE_PACKET, 16'h7FFF, 16'd0,    8'd1,  1'b1,
        '{OUT_DROP_FULL,     1'b0, 16'h0000, 16'd0, 5'd16}}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        write_cap(dir_table[i].value);
      end else begin
        for (int k = 0; k < int'(dir_table[i].reps); k++) begin
          send_item(dir_table[i].mode, dir_table[i].id + 16'(k), dir_table[i].value,
                    dir_table[i].fixed, dir_table[i].res);
        end
      end
    end

    // random part: one bucket size per segment, idling mix rotates
    seg_cap = '{1, 65535, $urandom_range(12, 2), $urandom_range(40, 13), 0,
                $urandom_range(6, 2), $urandom_range(24, 7), 10};
    for (int seg = 0; seg < NumSegments; seg++) begin
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      tick_pct = (seg % 2 == 0) ? 55 : 75;
      drain_queue();
      cap = 16'(seg_cap[seg]);
      write_cap(cap);
      for (int n = 0; n < SegmentItems; n++) begin
        // sender holds off until the block has nothing left to report
        if (n == SegmentItems / 2 || $urandom_range(59) == 0) wait_idle();
        if ($urandom_range(99) < tick_pct) begin
          // id and need are junk on a tick
          send_item(MODE_TICK, 16'($urandom), 16'($urandom), 1'b0, '0);
        end else begin
          if (cap == 16'd0) begin
            need = $urandom_range(1) ? 16'h0 : 16'($urandom_range(65535, 1));
          end else if (cap == 16'hFFFF || $urandom_range(99) < 85) begin
            // keep needs small enough to drain in a few dozen ticks
            need = 16'($urandom_range((cap > 16'd40) ? 40 : int'(cap), 0));
          end else begin
            need = 16'($urandom_range(65535, int'(cap) + 1));
          end
          send_item(MODE_PACKET, 16'($urandom), need, 1'b0, '0);
        end
      end
    end

    wait_idle();

    $display("covered %0d ticks and %0d arrivals over %0d bucket size writes and four idling mixes",
             ticks_sent, arrivals_sent, sizes_used);
    $display("%0d results checked: %0d releases, %0d oversize drops, %0d full drops, %0d bad",
             results_seen, releases_seen, oversize_seen, full_seen, fail_count);
    if (fail_count == 0 && shaped_q.size() == 0) begin
      $display("tb_token_bucket_packet_shaper passed");
    end else begin
      $display("tb_token_bucket_packet_shaper failed");
    end
    $finish;
  end

endmodule
